### design/cau_pkg.sv
// Shared types and command codes of the complex arithmetic unit.
package cau_pkg;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_CMP = 3'd4
  } cau_cmd_e;

  typedef struct packed {
    logic       valid;
    logic [2:0] cmd;
  } cau_op_t;

  typedef struct packed {
    logic is_less;
    logic is_greater;
    logic is_equal;
    logic overflow;
    logic div_zero;
  } cau_flags_t;

  typedef struct packed {
    logic       valid;
    logic       is_div;
    cau_flags_t flags;
  } cau_ctrl_t;

endpackage

### design/cau_req_if.sv
// Request channel interface: command and two complex operands.
interface cau_req_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                         valid;
  logic                         ready;
  logic [2:0]                   cmd;
  logic signed [DATA_WIDTH-1:0] a_re;
  logic signed [DATA_WIDTH-1:0] a_im;
  logic signed [DATA_WIDTH-1:0] b_re;
  logic signed [DATA_WIDTH-1:0] b_im;

  modport source (output valid, cmd, a_re, a_im, b_re, b_im, input ready);
  modport sink (input valid, cmd, a_re, a_im, b_re, b_im, output ready);
endinterface

### design/cau_rsp_if.sv
// Result channel interface: complex result and status flags.
interface cau_rsp_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] res_re;
  logic signed [DATA_WIDTH-1:0] res_im;
  logic                         is_less;
  logic                         is_greater;
  logic                         is_equal;
  logic                         overflow;
  logic                         div_zero;

  modport source (output valid, res_re, res_im, is_less, is_greater, is_equal, overflow,
                  div_zero, input ready);
  modport sink (input valid, res_re, res_im, is_less, is_greater, is_equal, overflow,
                div_zero, output ready);
endinterface

### design/cau_mul.sv
// Four-stage product pipeline: split partial products, sums and complex combination.
module cau_mul #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  cau_pkg::cau_op_t               op_i,
  input  logic signed [DATA_WIDTH-1:0]   a_re_i,
  input  logic signed [DATA_WIDTH-1:0]   a_im_i,
  input  logic signed [DATA_WIDTH-1:0]   b_re_i,
  input  logic signed [DATA_WIDTH-1:0]   b_im_i,
  output cau_pkg::cau_op_t               op_o,
  output logic signed [DATA_WIDTH-1:0]   a_re_o,
  output logic signed [DATA_WIDTH-1:0]   a_im_o,
  output logic signed [DATA_WIDTH-1:0]   b_re_o,
  output logic signed [DATA_WIDTH-1:0]   b_im_o,
  output logic signed [2*DATA_WIDTH:0]   xr_o,
  output logic signed [2*DATA_WIDTH:0]   xi_o,
  output logic [2*DATA_WIDTH-1:0]        den_o
);
  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int LO = W / 2;
  localparam int HI = W - LO;
  localparam int PW = 2 * W;

  typedef struct packed {
    logic signed [W-1:0] ar;
    logic signed [W-1:0] ai;
    logic signed [W-1:0] br;
    logic signed [W-1:0] bi;
  } opnd_t;

  cau_op_t op1_q, op2_q, op3_q, op4_q;
  opnd_t   opn1_q, opn2_q, opn3_q, opn4_q;

  logic signed [W-1:0]    opa [6];
  logic signed [W-1:0]    opb [6];
  logic signed [2*HI-1:0] hh_d [6];
  logic signed [2*HI-1:0] hh_q [6];
  logic signed [W:0]      hl_d [6];
  logic signed [W:0]      hl_q [6];
  logic signed [W:0]      lh_d [6];
  logic signed [W:0]      lh_q [6];
  logic [2*LO-1:0]        ll_d [6];
  logic [2*LO-1:0]        ll_q [6];
  logic signed [PW-1:0]   p_d [6];
  logic signed [PW-1:0]   p_q [6];
  logic signed [PW:0]     xr_d, xi_d, xr_q, xi_q;
  logic [PW-1:0]          den_d, den_q;
  logic signed [PW:0]     rr, ii, ir, ri;
  logic                   is_div;

  always_comb begin
    opa[0] = opn1_q.ar; opb[0] = opn1_q.br;
    opa[1] = opn1_q.ai; opb[1] = opn1_q.bi;
    opa[2] = opn1_q.ai; opb[2] = opn1_q.br;
    opa[3] = opn1_q.ar; opb[3] = opn1_q.bi;
    opa[4] = opn1_q.br; opb[4] = opn1_q.br;
    opa[5] = opn1_q.bi; opb[5] = opn1_q.bi;
    for (int k = 0; k < 6; k++) begin
      hh_d[k] = $signed(opa[k][W-1:LO]) * $signed(opb[k][W-1:LO]);
      hl_d[k] = $signed(opa[k][W-1:LO]) * $signed({1'b0, opb[k][LO-1:0]});
      lh_d[k] = $signed({1'b0, opa[k][LO-1:0]}) * $signed(opb[k][W-1:LO]);
      ll_d[k] = opa[k][LO-1:0] * opb[k][LO-1:0];
    end
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      p_d[k] = (PW'(hh_q[k]) <<< (2 * LO)) + ((PW'(hl_q[k]) + PW'(lh_q[k])) <<< LO)
             + $signed(PW'(ll_q[k]));
    end
  end

  always_comb begin
    is_div = (op3_q.cmd == CMD_DIV);
    rr     = $signed({p_q[0][PW-1], p_q[0]});
    ii     = $signed({p_q[1][PW-1], p_q[1]});
    ir     = $signed({p_q[2][PW-1], p_q[2]});
    ri     = $signed({p_q[3][PW-1], p_q[3]});
    xr_d   = is_div ? rr + ii : rr - ii;
    xi_d   = is_div ? ir - ri : ir + ri;
    den_d  = $unsigned(p_q[4]) + $unsigned(p_q[5]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op1_q <= '0;
      op2_q <= '0;
      op3_q <= '0;
      op4_q <= '0;
    end else if (en_i) begin
      op1_q <= op_i;
      op2_q <= op1_q;
      op3_q <= op2_q;
      op4_q <= op3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      opn1_q <= {a_re_i, a_im_i, b_re_i, b_im_i};
      opn2_q <= opn1_q;
      opn3_q <= opn2_q;
      opn4_q <= opn3_q;
      hh_q   <= hh_d;
      hl_q   <= hl_d;
      lh_q   <= lh_d;
      ll_q   <= ll_d;
      p_q    <= p_d;
      xr_q   <= xr_d;
      xi_q   <= xi_d;
      den_q  <= den_d;
    end
  end

  assign op_o   = op4_q;
  assign a_re_o = opn4_q.ar;
  assign a_im_o = opn4_q.ai;
  assign b_re_o = opn4_q.br;
  assign b_im_o = opn4_q.bi;
  assign xr_o   = xr_q;
  assign xi_o   = xi_q;
  assign den_o  = den_q;

endmodule

### design/cau_div.sv
// Pipelined restoring divider, one quotient bit per stage, with bypass of other results.
module cau_div #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  cau_pkg::cau_ctrl_t            ctrl_i,
  input  logic signed [DATA_WIDTH-1:0]  res_re_i,
  input  logic signed [DATA_WIDTH-1:0]  res_im_i,
  input  logic                          neg_re_i,
  input  logic                          neg_im_i,
  input  logic [2*DATA_WIDTH:0]         mag_re_i,
  input  logic [2*DATA_WIDTH:0]         mag_im_i,
  input  logic [2*DATA_WIDTH-1:0]       den_i,
  output cau_pkg::cau_ctrl_t            ctrl_o,
  output logic signed [DATA_WIDTH-1:0]  res_re_o,
  output logic signed [DATA_WIDTH-1:0]  res_im_o,
  output logic                          neg_re_o,
  output logic                          neg_im_o,
  output logic [DATA_WIDTH:0]           q_re_o,
  output logic [DATA_WIDTH:0]           q_im_o
);
  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int XW = 2 * W + 1;
  localparam int NW = XW + FRAC_BITS;
  localparam int CW = (NW > 3 * W) ? NW : 3 * W;

  cau_ctrl_t           ctrl_q   [W+1];
  logic signed [W-1:0] res_re_q [W+1];
  logic signed [W-1:0] res_im_q [W+1];
  logic                neg_re_q [W+1];
  logic                neg_im_q [W+1];
  logic                big_re_q [W+1];
  logic                big_im_q [W+1];
  logic [NW-1:0]       rem_re_q [W+1];
  logic [NW-1:0]       rem_im_q [W+1];
  logic [W-1:0]        q_re_q   [W+1];
  logic [W-1:0]        q_im_q   [W+1];
  logic [2*W-1:0]      den_q    [W+1];

  logic [NW-1:0] num_re, num_im;
  logic [CW-1:0] den_top;

  assign num_re  = NW'(mag_re_i) << FRAC_BITS;
  assign num_im  = NW'(mag_im_i) << FRAC_BITS;
  assign den_top = CW'(den_i) << W;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q[0] <= '0;
    end else if (en_i) begin
      ctrl_q[0] <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_re_q[0] <= res_re_i;
      res_im_q[0] <= res_im_i;
      neg_re_q[0] <= neg_re_i;
      neg_im_q[0] <= neg_im_i;
      big_re_q[0] <= CW'(num_re) >= den_top;
      big_im_q[0] <= CW'(num_im) >= den_top;
      rem_re_q[0] <= num_re;
      rem_im_q[0] <= num_im;
      q_re_q[0]   <= '0;
      q_im_q[0]   <= '0;
      den_q[0]    <= den_i;
    end
  end

  for (genvar j = 0; j < W; j++) begin : g_bit
    localparam int I = W - 1 - j;
    logic [CW-1:0] trial;
    logic          ge_re, ge_im;

    assign trial = CW'(den_q[j]) << I;
    assign ge_re = CW'(rem_re_q[j]) >= trial;
    assign ge_im = CW'(rem_im_q[j]) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctrl_q[j+1] <= '0;
      end else if (en_i) begin
        ctrl_q[j+1] <= ctrl_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        res_re_q[j+1] <= res_re_q[j];
        res_im_q[j+1] <= res_im_q[j];
        neg_re_q[j+1] <= neg_re_q[j];
        neg_im_q[j+1] <= neg_im_q[j];
        big_re_q[j+1] <= big_re_q[j];
        big_im_q[j+1] <= big_im_q[j];
        rem_re_q[j+1] <= ge_re ? rem_re_q[j] - trial[NW-1:0] : rem_re_q[j];
        rem_im_q[j+1] <= ge_im ? rem_im_q[j] - trial[NW-1:0] : rem_im_q[j];
        q_re_q[j+1]   <= q_re_q[j] | (W'(ge_re) << I);
        q_im_q[j+1]   <= q_im_q[j] | (W'(ge_im) << I);
        den_q[j+1]    <= den_q[j];
      end
    end
  end

  assign ctrl_o   = ctrl_q[W];
  assign res_re_o = res_re_q[W];
  assign res_im_o = res_im_q[W];
  assign neg_re_o = neg_re_q[W];
  assign neg_im_o = neg_im_q[W];
  assign q_re_o   = {big_re_q[W], q_re_q[W]};
  assign q_im_o   = {big_im_q[W], q_im_q[W]};

endmodule

### design/complex_arith_unit_core.sv
// Top level of the pipelined complex arithmetic unit.
//
// The request channel carries a command (add, subtract, multiply, divide,
// compare) and two complex operands in signed fixed point with FRAC_BITS
// fraction bits; the result channel returns one item per request: the
// saturated complex result and the less, greater, equal, overflow and
// divide-by-zero flags.
// Throughput is one request per cycle while the receiver does not stall.
// A request passes four product stages, one combine and saturate stage,
// DATA_WIDTH + 1 divider stages (one quotient bit each) and the output
// register before its result is valid. Every command takes the same
// path, so results leave in request order.
// The whole pipeline advances whenever the output register is empty or is
// being taken; while the receiver stalls, every stage holds and ready is low.
// Reset clears all valid bits; no request is in flight afterwards.
module complex_arith_unit_core #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 24
) (
  input logic      clk_i,
  input logic      rst_ni,
  cau_req_if.sink  req_i,
  cau_rsp_if.source rsp_o
);
  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int XW = 2 * W + 1;

  logic                en;
  cau_op_t             op_in, op4;
  logic signed [W-1:0] ar4, ai4, br4, bi4;
  logic signed [XW-1:0] xr4, xi4;
  logic [2*W-1:0]      den4;

  cau_ctrl_t           c5_d, c5_q;
  logic signed [W-1:0] res5_re_d, res5_im_d, res5_re_q, res5_im_q;
  logic                neg5_re_d, neg5_im_d, neg5_re_q, neg5_im_q;
  logic [XW-1:0]       mag5_re_d, mag5_im_d, mag5_re_q, mag5_im_q;
  logic [2*W-1:0]      den5_q;

  cau_ctrl_t           cd;
  logic signed [W-1:0] resd_re, resd_im;
  logic                negd_re, negd_im;
  logic [W:0]          qd_re, qd_im;

  logic                out_valid_q;
  logic signed [W-1:0] out_re_d, out_im_d, out_re_q, out_im_q;
  cau_flags_t          out_fl_d, out_fl_q;

  function automatic logic [W:0] sat_m(input logic neg, input logic [XW-1:0] m);
    logic [XW-1:0] lim;
    logic [W-1:0]  val;
    lim = (XW'(1) << (W - 1)) - XW'(!neg);
    if (m > lim) begin
      val = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      return {1'b1, val};
    end
    val = neg ? -m[W-1:0] : m[W-1:0];
    return {1'b0, val};
  endfunction

  function automatic logic [W:0] sat_s(input logic [W:0] s);
    logic [W-1:0] val;
    if (s[W] != s[W-1]) begin
      val = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      return {1'b1, val};
    end
    val = s[W-1:0];
    return {1'b0, val};
  endfunction

  assign en          = !out_valid_q || rsp_o.ready;
  assign req_i.ready = en;
  assign op_in       = '{valid: req_i.valid, cmd: req_i.cmd};

  cau_mul #(.DATA_WIDTH(W)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .op_i   (op_in),
    .a_re_i (req_i.a_re),
    .a_im_i (req_i.a_im),
    .b_re_i (req_i.b_re),
    .b_im_i (req_i.b_im),
    .op_o   (op4),
    .a_re_o (ar4),
    .a_im_o (ai4),
    .b_re_o (br4),
    .b_im_o (bi4),
    .xr_o   (xr4),
    .xi_o   (xi4),
    .den_o  (den4)
  );

  always_comb begin
    logic [W:0]    s_re, s_im, sr, si;
    logic [XW-1:0] sh_re, sh_im;
    c5_d       = '0;
    c5_d.valid = op4.valid;
    res5_re_d  = '0;
    res5_im_d  = '0;
    neg5_re_d  = xr4[XW-1];
    neg5_im_d  = xi4[XW-1];
    mag5_re_d  = neg5_re_d ? -xr4 : xr4;
    mag5_im_d  = neg5_im_d ? -xi4 : xi4;
    s_re       = '0;
    s_im       = '0;
    sr         = '0;
    si         = '0;
    sh_re      = mag5_re_d >> FRAC_BITS;
    sh_im      = mag5_im_d >> FRAC_BITS;
    case (op4.cmd)
      CMD_ADD, CMD_SUB: begin
        if (op4.cmd == CMD_SUB) begin
          s_re = {ar4[W-1], ar4} - {br4[W-1], br4};
          s_im = {ai4[W-1], ai4} - {bi4[W-1], bi4};
        end else begin
          s_re = {ar4[W-1], ar4} + {br4[W-1], br4};
          s_im = {ai4[W-1], ai4} + {bi4[W-1], bi4};
        end
        sr = sat_s(s_re);
        si = sat_s(s_im);
        res5_re_d = sr[W-1:0];
        res5_im_d = si[W-1:0];
        c5_d.flags.overflow = sr[W] | si[W];
      end
      CMD_MUL: begin
        sr = sat_m(neg5_re_d, sh_re);
        si = sat_m(neg5_im_d, sh_im);
        res5_re_d = sr[W-1:0];
        res5_im_d = si[W-1:0];
        c5_d.flags.overflow = sr[W] | si[W];
      end
      CMD_DIV: begin
        if (den4 == '0) begin
          c5_d.flags.div_zero = 1'b1;
        end else begin
          c5_d.is_div = 1'b1;
        end
      end
      CMD_CMP: begin
        c5_d.flags.is_less    = (ar4 < br4) || (ar4 == br4 && ai4 < bi4);
        c5_d.flags.is_greater = (ar4 > br4) || (ar4 == br4 && ai4 > bi4);
        c5_d.flags.is_equal   = (ar4 == br4) && (ai4 == bi4);
      end
      default: begin
        c5_d.is_div = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c5_q <= '0;
    end else if (en) begin
      c5_q <= c5_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res5_re_q <= res5_re_d;
      res5_im_q <= res5_im_d;
      neg5_re_q <= neg5_re_d;
      neg5_im_q <= neg5_im_d;
      mag5_re_q <= mag5_re_d;
      mag5_im_q <= mag5_im_d;
      den5_q    <= den4;
    end
  end

  cau_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .ctrl_i   (c5_q),
    .res_re_i (res5_re_q),
    .res_im_i (res5_im_q),
    .neg_re_i (neg5_re_q),
    .neg_im_i (neg5_im_q),
    .mag_re_i (mag5_re_q),
    .mag_im_i (mag5_im_q),
    .den_i    (den5_q),
    .ctrl_o   (cd),
    .res_re_o (resd_re),
    .res_im_o (resd_im),
    .neg_re_o (negd_re),
    .neg_im_o (negd_im),
    .q_re_o   (qd_re),
    .q_im_o   (qd_im)
  );

  always_comb begin
    logic [W:0] dr, di;
    dr       = sat_m(negd_re, XW'(qd_re));
    di       = sat_m(negd_im, XW'(qd_im));
    out_fl_d = cd.flags;
    if (cd.is_div) begin
      out_re_d = dr[W-1:0];
      out_im_d = di[W-1:0];
      out_fl_d.overflow = dr[W] | di[W];
    end else begin
      out_re_d = resd_re;
      out_im_d = resd_im;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= cd.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_re_q <= out_re_d;
      out_im_q <= out_im_d;
      out_fl_q <= out_fl_d;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.res_re     = out_re_q;
  assign rsp_o.res_im     = out_im_q;
  assign rsp_o.is_less    = out_fl_q.is_less;
  assign rsp_o.is_greater = out_fl_q.is_greater;
  assign rsp_o.is_equal   = out_fl_q.is_equal;
  assign rsp_o.overflow   = out_fl_q.overflow;
  assign rsp_o.div_zero   = out_fl_q.div_zero;

  a_cmp_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0({out_fl_q.is_less, out_fl_q.is_greater, out_fl_q.is_equal}))
    else $error("compare flags not exclusive");

  a_cmp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_fl_q.is_less || out_fl_q.is_greater || out_fl_q.is_equal)
    |-> out_re_q == '0 && out_im_q == '0 && !out_fl_q.overflow && !out_fl_q.div_zero)
    else $error("compare request with nonzero result");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_fl_q.div_zero |-> out_re_q == '0 && out_im_q == '0
    && !out_fl_q.overflow)
    else $error("divide by zero with nonzero result");

  a_ovf_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_fl_q.overflow |->
    out_re_q == {1'b1, {(W-1){1'b0}}} || out_re_q == {1'b0, {(W-1){1'b1}}} ||
    out_im_q == {1'b1, {(W-1){1'b0}}} || out_im_q == {1'b0, {(W-1){1'b1}}})
    else $error("overflow without a saturated part");

endmodule
